@@ hdl/hcc_pkg.sv @@
// ----------------------------------------------------------------------------
// hcc_pkg
// Shared types and constants of the heater command unit with chatter guard.
// ----------------------------------------------------------------------------
package hcc_pkg;

  localparam int unsigned COUNT_WIDTH = 8;
  localparam int unsigned TEMP_WIDTH  = 16;
  localparam int unsigned CMP_WIDTH   = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;

  localparam int unsigned CFG_IDX_WIDTH  = 3;
  localparam int unsigned CFG_DATA_WIDTH = 16;

  typedef logic [COUNT_WIDTH-1:0]       count_t;
  typedef logic [CMP_WIDTH-1:0]         cmp_t;
  typedef logic signed [TEMP_WIDTH-1:0] temp_t;

  localparam count_t COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [1:0] {
    LvlOff     = 2'd0,
    LvlFull    = 2'd1,
    LvlReduced = 2'd2
  } level_e;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    RegMediumThreshold = 3'd0,
    RegMaxThreshold    = 3'd1,
    RegChatAllow       = 3'd2,
    RegSettleLength    = 3'd3,
    RegBurnLimit       = 3'd4,
    RegDriveScale      = 3'd5
  } cfg_reg_e;

  localparam logic [15:0] RST_MEDIUM_THRESHOLD = 16'd660;
  localparam logic [15:0] RST_MAX_THRESHOLD    = 16'd700;
  localparam logic [7:0]  RST_CHAT_ALLOW       = 8'd2;
  localparam logic [7:0]  RST_SETTLE_LENGTH    = 8'd5;
  localparam logic [7:0]  RST_BURN_LIMIT       = 8'd5;
  localparam logic [7:0]  RST_DRIVE_SCALE      = 8'd10;

  typedef struct packed {
    logic [15:0] medium_threshold;
    logic [15:0] max_threshold;
    logic [7:0]  chat_allow;
    logic [7:0]  settle_length;
    logic [7:0]  burn_limit;
    logic [7:0]  drive_scale;
  } cfg_t;

  typedef struct packed {
    logic [8:0] drive_value;
    logic [1:0] heater_level;
    logic [7:0] chatter_value;
    logic [7:0] on_run;
    logic [7:0] off_run;
  } result_t;

  // low TEMP_WIDTH bits of a 16 bit field, read as signed
  function automatic temp_t to_temp(logic [15:0] v);
    return temp_t'(v);
  endfunction

  function automatic cmp_t cnt_ext(count_t c);
    return cmp_t'(c);
  endfunction

  function automatic cmp_t cfg_ext(logic [7:0] v);
    return cmp_t'(v);
  endfunction

  function automatic count_t sat_inc(count_t c);
    return (c == COUNT_MAX) ? COUNT_MAX : count_t'(c + count_t'(1));
  endfunction

endpackage

@@ hdl/hcc_interfaces.sv @@
// ----------------------------------------------------------------------------
// hcc interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
interface hcc_in_if;
  import hcc_pkg::*;

  logic               valid;
  logic               ready;
  logic signed [15:0] temp_sample;

  modport source (output valid, output temp_sample, input ready);
  modport sink   (input valid, input temp_sample, output ready);
endinterface

interface hcc_out_if;
  import hcc_pkg::*;

  logic       valid;
  logic       ready;
  logic [8:0] drive_value;
  logic [1:0] heater_level;
  logic [7:0] chatter_value;
  logic [7:0] on_run;
  logic [7:0] off_run;

  modport source (output valid, output drive_value, output heater_level,
                  output chatter_value, output on_run, output off_run, input ready);
  modport sink   (input valid, input drive_value, input heater_level,
                  input chatter_value, input on_run, input off_run, output ready);
endinterface

interface hcc_cfg_if;
  import hcc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CFG_IDX_WIDTH-1:0]  index;
  logic [CFG_DATA_WIDTH-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/heater_command_with_chatter_guard_unit.sv @@
// ----------------------------------------------------------------------------
// heater_command_with_chatter_guard_unit
// Heater level and drive from room temperature, with chatter guard and
// burnout cutoff.
// ----------------------------------------------------------------------------
//  channel  dir  word                                            handshake
//  in_i     in   temp_sample                                     valid/ready
//  res_o    out  drive_value heater_level chatter_value on/off   valid/ready
//  cfg_i    in   index, data                                     valid/ready
//
//  One word per cycle sustained while res_o.ready holds; a sample passes
//  the input register, then the result register after the decision logic.
//  Reset restores register defaults and clears level and counters.
//  A held result stalls the input register only when both are full.
//  cfg_i is always ready.
// ----------------------------------------------------------------------------
module heater_command_with_chatter_guard_unit (
  input  logic   clk_i,
  input  logic   rst_ni,
  hcc_in_if.sink   in_i,
  hcc_out_if.source res_o,
  hcc_cfg_if.sink  cfg_i
);
  import hcc_pkg::*;

  cfg_t        cfg;
  result_t     step_res;
  logic        in_valid_q, in_valid_d;
  logic [15:0] temp_q;
  logic        res_valid_q, res_valid_d;
  result_t     res_q;
  logic        advance;
  logic        in_take;

  hcc_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  hcc_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .temp_sample_i (temp_q),
    .cfg_i         (cfg),
    .result_o      (step_res)
  );

  assign advance    = in_valid_q && (!res_valid_q || res_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    res_valid_d = res_valid_q;
    if (advance) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      temp_q <= $unsigned(in_i.temp_sample);
    end
    if (advance) begin
      res_q <= step_res;
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.drive_value   = res_q.drive_value;
  assign res_o.heater_level  = res_q.heater_level;
  assign res_o.chatter_value = res_q.chatter_value;
  assign res_o.on_run        = res_q.on_run;
  assign res_o.off_run       = res_q.off_run;

`ifndef NO_ASSERTIONS
  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> res_valid_q)
    else $error("result register not filled after advance");

  a_stalled_sample_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(temp_q))
    else $error("stalled sample lost");

  a_level_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> res_q.heater_level != 2'd3)
    else $error("illegal heater level");
`endif

endmodule

@@ hdl/hcc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// hcc_cfg_regs
// Configuration register file; one register write per accepted word.
// ----------------------------------------------------------------------------
module hcc_cfg_regs (
  input  logic         clk_i,
  input  logic         rst_ni,
  hcc_cfg_if.sink      cfg_i,
  output hcc_pkg::cfg_t cfg_o
);
  import hcc_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;
  logic wr_en;

  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (cfg_i.index)
        RegMediumThreshold: cfg_d.medium_threshold = cfg_i.data;
        RegMaxThreshold:    cfg_d.max_threshold    = cfg_i.data;
        RegChatAllow:       cfg_d.chat_allow       = cfg_i.data[7:0];
        RegSettleLength:    cfg_d.settle_length    = cfg_i.data[7:0];
        RegBurnLimit:       cfg_d.burn_limit       = cfg_i.data[7:0];
        RegDriveScale:      cfg_d.drive_scale      = cfg_i.data[7:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.medium_threshold <= RST_MEDIUM_THRESHOLD;
      cfg_q.max_threshold    <= RST_MAX_THRESHOLD;
      cfg_q.chat_allow       <= RST_CHAT_ALLOW;
      cfg_q.settle_length    <= RST_SETTLE_LENGTH;
      cfg_q.burn_limit       <= RST_BURN_LIMIT;
      cfg_q.drive_scale      <= RST_DRIVE_SCALE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/hcc_core.sv @@
// ----------------------------------------------------------------------------
// hcc_core
// Level decision, chatter guard, burnout cutoff and run counters.
// ----------------------------------------------------------------------------
module hcc_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [15:0]     temp_sample_i,
  input  hcc_pkg::cfg_t   cfg_i,
  output hcc_pkg::result_t result_o
);
  import hcc_pkg::*;

  level_e prev_q, prev_d;
  count_t chat_q, chat_d;
  count_t on_q, on_d;
  count_t off_q, off_d;

  temp_t  temp, med, mx;
  level_e raw_lvl, lvl;
  count_t chat_clr;
  logic   settled, burnout;

  always_comb begin
    temp = to_temp(temp_sample_i);
    med  = to_temp(cfg_i.medium_threshold);
    mx   = to_temp(cfg_i.max_threshold);

    if (temp >= med && temp < mx) begin
      raw_lvl = LvlReduced;
    end else if (temp >= mx) begin
      raw_lvl = LvlOff;
    end else begin
      raw_lvl = LvlFull;
    end

    settled  = (cnt_ext(off_q) >= cfg_ext(cfg_i.settle_length)) ||
               (cnt_ext(on_q) >= cfg_ext(cfg_i.settle_length));
    chat_clr = settled ? '0 : chat_q;
    chat_d   = (raw_lvl != prev_q) ? sat_inc(chat_clr) : chat_clr;

    lvl = (cnt_ext(chat_d) > cfg_ext(cfg_i.chat_allow)) ? prev_q : raw_lvl;
    burnout = cnt_ext(on_q) >= cfg_ext(cfg_i.burn_limit);
    if (burnout) begin
      lvl = LvlOff;
    end

    if (lvl == LvlOff) begin
      on_d  = '0;
      off_d = sat_inc(off_q);
    end else begin
      on_d  = sat_inc(on_q);
      off_d = '0;
    end
    prev_d = lvl;

    result_o.drive_value   = 9'(10'(lvl) * 10'(cfg_i.drive_scale));
    result_o.heater_level  = lvl;
    result_o.chatter_value = 8'(chat_d);
    result_o.on_run        = 8'(on_d);
    result_o.off_run       = 8'(off_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= LvlOff;
      chat_q <= '0;
      on_q   <= '0;
      off_q  <= '0;
    end else if (step_i) begin
      prev_q <= prev_d;
      chat_q <= chat_d;
      on_q   <= on_d;
      off_q  <= off_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_runs_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(on_q != '0 && off_q != '0))
    else $error("on and off runs both nonzero");

  a_burnout_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && burnout |=> prev_q == LvlOff && on_q == '0)
    else $error("burnout did not force heater off");

  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(prev_q) && $stable(chat_q) && $stable(on_q) && $stable(off_q))
    else $error("state changed without a step");
`endif

endmodule
